@@ src/swr_pkg.sv @@
// Package for the stopwatch seven-segment renderer: transaction types, face geometry,
// reciprocal constants and the segment and decimal helper functions.
// Depends on nothing; every other file imports it.
package swr_pkg;

	localparam int PANEL_WIDTH  = 368;
	localparam int PANEL_HEIGHT = 448;
	localparam int NUM_CELLS    = 6;
	localparam int CFG_IDX_W    = 1;

	localparam logic [CFG_IDX_W-1:0] CFG_FG_COLOR = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_BG_COLOR = 1'b1;

	localparam logic [8:0] PANEL_W9  = 9'd368;
	localparam logic [8:0] PANEL_H9  = 9'd448;
	localparam logic [8:0] LAST_COL  = 9'd367;

	localparam logic [8:0] CELL_W    = 9'd48;
	localparam logic [8:0] STROKE    = 9'd18;
	localparam logic [8:0] RIGHT_OFS = 9'd30;
	localparam logic [NUM_CELLS-1:0][8:0] CELL_X = {
		9'd386, 9'd326, 9'd230, 9'd170, 9'd74, 9'd14
	};

	localparam logic [8:0] Y_A_LO  = 9'd124;
	localparam logic [8:0] Y_UA_LO = 9'd142;
	localparam logic [8:0] Y_G_LO  = 9'd175;
	localparam logic [8:0] Y_LD_LO = 9'd193;
	localparam logic [8:0] Y_D_LO  = 9'd226;
	localparam logic [8:0] Y_D_HI  = 9'd244;

	localparam logic [8:0] COLON_A_LO = 9'd137;
	localparam logic [8:0] COLON_A_HI = 9'd155;
	localparam logic [8:0] COLON_B_LO = 9'd293;
	localparam logic [8:0] COLON_B_HI = 9'd311;
	localparam logic [8:0] DOT1_LO    = 9'd155;
	localparam logic [8:0] DOT1_HI    = 9'd173;
	localparam logic [8:0] DOT2_LO    = 9'd195;
	localparam logic [8:0] DOT2_HI    = 9'd213;

	// Reciprocals: floor(n / d) = (n * M) >> K, exact over the operand range used.
	localparam logic [31:0] DIV10_MUL   = 32'hCCCC_CCCD;
	localparam int          DIV10_SH    = 35;
	localparam logic [29:0] DIV6000_MUL = 30'd733007752;
	localparam int          DIV6000_SH  = 42;
	localparam logic [17:0] DIV100Q_MUL = 18'd167773;
	localparam int          DIV100Q_SH  = 24;
	localparam logic [13:0] DIV100R_MUL = 14'd10486;
	localparam int          DIV100R_SH  = 20;
	localparam logic [12:0] CS_PER_MIN  = 13'd6000;
	localparam logic [6:0]  HUNDRED     = 7'd100;

	typedef struct packed {
		logic        req_type;
		logic [31:0] now_ms;
		logic        boot_reset;
		logic        short_press;
		logic [8:0]  pixel_x;
		logic [8:0]  pixel_y;
	} swr_req_t;

	typedef struct packed {
		logic [3:0]  minute_tens;
		logic [3:0]  minute_units;
		logic [3:0]  second_tens;
		logic [3:0]  second_units;
		logic [3:0]  centi_tens;
		logic [3:0]  centi_units;
		logic [15:0] pixel_color;
	} swr_rsp_t;

	typedef logic [NUM_CELLS-1:0][3:0] swr_digits_t;

	typedef struct packed {
		logic [NUM_CELLS-1:0] x_full;
		logic [NUM_CELLS-1:0] x_left;
		logic [NUM_CELLS-1:0] x_right;
		logic                 y_a;
		logic                 y_ua;
		logic                 y_g;
		logic                 y_ld;
		logic                 y_d;
		logic                 colon;
	} swr_geom_t;

	function automatic logic [6:0] seg_bits(input logic [3:0] digit);
		logic [6:0] segs;
		unique case (digit)
			4'd0: segs = 7'h3F;
			4'd1: segs = 7'h06;
			4'd2: segs = 7'h5B;
			4'd3: segs = 7'h4F;
			4'd4: segs = 7'h66;
			4'd5: segs = 7'h6D;
			4'd6: segs = 7'h7D;
			4'd7: segs = 7'h07;
			4'd8: segs = 7'h7F;
			4'd9: segs = 7'h6F;
			default: segs = 7'h00;
		endcase
		return segs;
	endfunction

	function automatic logic [7:0] dec_split(input logic [6:0] value);
		logic [3:0] tens;
		logic [6:0] units;
		tens = 4'd0;
		for (int k = 1; k < 10; k++) begin
			if (value >= 7'(10 * k)) tens = tens + 4'd1;
		end
		units = value - 7'({tens, 3'b000}) - 7'({tens, 1'b0});
		return {tens, units[3:0]};
	endfunction

endpackage

@@ src/swr_geom.sv @@
// Face geometry for one landscape point: which cell columns, stroke rows and colon dots
// the point falls in, independent of the digits shown. Uses swr_pkg.
module swr_geom (
	input  logic            on_panel,
	input  logic [8:0]      lx,
	input  logic [8:0]      ly,
	output swr_pkg::swr_geom_t geom
);
	import swr_pkg::*;

	logic dot_x;
	logic dot_y;

	always_comb begin
		for (int i = 0; i < NUM_CELLS; i++) begin
			geom.x_full[i]  = on_panel && lx >= CELL_X[i] && lx < CELL_X[i] + CELL_W;
			geom.x_left[i]  = on_panel && lx >= CELL_X[i] && lx < CELL_X[i] + STROKE;
			geom.x_right[i] = on_panel && lx >= CELL_X[i] + RIGHT_OFS
				&& lx < CELL_X[i] + CELL_W;
		end
		geom.y_a  = ly >= Y_A_LO  && ly < Y_UA_LO;
		geom.y_ua = ly >= Y_UA_LO && ly < Y_G_LO;
		geom.y_g  = ly >= Y_G_LO  && ly < Y_LD_LO;
		geom.y_ld = ly >= Y_LD_LO && ly < Y_D_LO;
		geom.y_d  = ly >= Y_D_LO  && ly < Y_D_HI;
		dot_x = (lx >= COLON_A_LO && lx < COLON_A_HI) || (lx >= COLON_B_LO && lx < COLON_B_HI);
		dot_y = (ly >= DOT1_LO && ly < DOT1_HI) || (ly >= DOT2_LO && ly < DOT2_HI);
		geom.colon = on_panel && dot_x && dot_y;
	end

endmodule

@@ src/swr_glyph.sv @@
// Combines precomputed face geometry with the stored digits, applying the joined-stroke
// rule for the vertical segments, and reports whether the pixel is foreground. Uses swr_pkg.
module swr_glyph (
	input  swr_pkg::swr_geom_t   geom,
	input  swr_pkg::swr_digits_t digits,
	output logic                 hit
);
	import swr_pkg::*;

	logic [6:0] segs;
	logic       row_up;
	logic       row_lo;
	logic       row_full;
	logic       cell_hit;

	always_comb begin
		hit = geom.colon;
		for (int i = 0; i < NUM_CELLS; i++) begin
			segs     = seg_bits(digits[i]);
			row_up   = segs[0] ? geom.y_ua : (geom.y_a || geom.y_ua);
			row_lo   = segs[3] ? geom.y_ld : (geom.y_ld || geom.y_d);
			row_full = row_up || geom.y_g || row_lo;
			cell_hit = geom.x_full[i] && ((segs[0] && geom.y_a) || (segs[6] && geom.y_g)
				|| (segs[3] && geom.y_d));
			if (!segs[6] && segs[5] && segs[4]) begin
				cell_hit = cell_hit || (geom.x_left[i] && row_full);
			end else begin
				cell_hit = cell_hit || (geom.x_left[i]
					&& ((segs[5] && row_up) || (segs[4] && row_lo)));
			end
			if (!segs[6] && segs[1] && segs[2]) begin
				cell_hit = cell_hit || (geom.x_right[i] && row_full);
			end else begin
				cell_hit = cell_hit || (geom.x_right[i]
					&& ((segs[1] && row_up) || (segs[2] && row_lo)));
			end
			hit = hit || cell_hit;
		end
	end

endmodule

@@ src/stopwatch_seven_segment_renderer.sv @@
// Top level of the stopwatch seven-segment renderer: run state, six-stage pipeline for
// time-to-digit conversion and pixel queries, result register. Uses swr_pkg, swr_geom, swr_glyph.
//
//   channel  signals                        direction  moves
//   req      req_valid, req_stall, req_data  in         one tick or pixel query
//   rsp      rsp_valid, rsp_stall, rsp_data  out        six digits and a pixel color
//   cfg      cfg_we, cfg_index, cfg_data     in         foreground / background color
//
// Every transaction raises rsp_valid from the result register; one new transaction is accepted
// each cycle while req_stall is low. The depth is set by the chain of four reciprocal multiplies.
// A tick's run-state update happens as it leaves the first stage; its digits are stored
// as it enters the result register, so a query right behind it already sees them.
// A stall on rsp fills the pipeline bubbles first and then holds req_stall high.
// Reset stops the stopwatch, shows 00:00:00 and sets the colors to 0x0000 / 0xFFFF.
module stopwatch_seven_segment_renderer (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             req_valid,
	output logic                             req_stall,
	input  swr_pkg::swr_req_t                req_data,
	output logic                             rsp_valid,
	input  logic                             rsp_stall,
	output swr_pkg::swr_rsp_t                rsp_data,
	input  logic                             cfg_we,
	input  logic [swr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [15:0]                      cfg_data
);
	import swr_pkg::*;

	logic [6:1] vld_q;
	logic [6:1] rdy;
	logic       out_rdy;
	logic       rsp_vld_q;
	logic       rsp_qry_q;
	swr_rsp_t   rsp_q;

	logic        run_q;
	logic [31:0] acc_q;
	logic [31:0] seg_q;
	swr_digits_t digit_q;
	logic [15:0] fg_q;
	logic [15:0] bg_q;

	swr_req_t    item_s1;
	logic        tick_go;
	logic        run0;
	logic [31:0] acc0;
	logic [31:0] elapsed;
	logic [31:0] acc_run;
	logic [31:0] shown;
	logic        on_panel;
	logic [8:0]  ly_calc;

	logic        qry_s2;
	logic [31:0] shown_s2;
	logic        on_s2;
	logic [8:0]  lx_s2;
	logic [8:0]  ly_s2;
	logic [63:0] prod10;
	swr_geom_t   geom_calc;

	logic        qry_s3;
	logic [28:0] cs_s3;
	swr_geom_t   geom_s3;
	logic [58:0] prod6000;

	logic        qry_s4;
	logic [28:0] cs_s4;
	logic [16:0] qm_s4;
	swr_geom_t   geom_s4;
	logic [28:0] rem_full;
	logic [34:0] prod_qh;

	logic        qry_s5;
	logic [16:0] qm_s5;
	logic [9:0]  qh_s5;
	logic [12:0] rem_s5;
	swr_geom_t   geom_s5;
	logic [16:0] mm_full;
	logic [26:0] prod_sq;

	logic        qry_s6;
	logic [6:0]  mm_s6;
	logic [5:0]  sq_s6;
	logic [12:0] rem_s6;
	swr_geom_t   geom_s6;
	logic [12:0] cs_full;
	logic [7:0]  mm_dec;
	logic [7:0]  ss_dec;
	logic [7:0]  cs_dec;
	swr_digits_t tick_digits;
	logic        pix_hit;

	// Handshake and stage advance.
	always_comb begin
		out_rdy = !rsp_vld_q || !rsp_stall;
		rdy[6]  = !vld_q[6] || out_rdy;
		for (int i = 5; i >= 1; i--) begin
			rdy[i] = !vld_q[i] || rdy[i+1];
		end
	end

	assign req_stall = !rdy[1];
	assign rsp_valid = rsp_vld_q;
	assign rsp_data  = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			rsp_vld_q <= 1'b0;
		end else begin
			if (rdy[1]) vld_q[1] <= req_valid;
			for (int i = 2; i <= 6; i++) begin
				if (rdy[i]) vld_q[i] <= vld_q[i-1];
			end
			if (out_rdy) rsp_vld_q <= vld_q[6];
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fg_q <= 16'h0000;
			bg_q <= 16'hFFFF;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_FG_COLOR: fg_q <= cfg_data;
				CFG_BG_COLOR: bg_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Stage 1: run state update and displayed time.
	always_ff @(posedge clk) begin
		if (rdy[1]) item_s1 <= req_data;
	end

	always_comb begin
		tick_go  = vld_q[1] && rdy[2] && !item_s1.req_type;
		run0     = item_s1.boot_reset ? 1'b0 : run_q;
		acc0     = item_s1.boot_reset ? 32'd0 : acc_q;
		elapsed  = item_s1.now_ms - seg_q;
		acc_run  = acc0 + elapsed;
		shown    = run0 ? acc_run : acc0;
		on_panel = item_s1.pixel_x < PANEL_W9 && item_s1.pixel_y < PANEL_H9;
		ly_calc  = LAST_COL - item_s1.pixel_x;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			acc_q <= '0;
			seg_q <= '0;
		end else if (tick_go) begin
			if (item_s1.short_press) begin
				run_q <= !run0;
				acc_q <= run0 ? acc_run : acc0;
				if (!run0) seg_q <= item_s1.now_ms;
			end else begin
				run_q <= run0;
				acc_q <= acc0;
			end
		end
	end

	// Stage 2: centiseconds = shown / 10; pixel geometry.
	always_ff @(posedge clk) begin
		if (rdy[2]) begin
			qry_s2   <= item_s1.req_type;
			shown_s2 <= shown;
			on_s2    <= on_panel;
			lx_s2    <= item_s1.pixel_y;
			ly_s2    <= ly_calc;
		end
	end

	assign prod10 = 64'(shown_s2) * 64'(DIV10_MUL);

	swr_geom u_geom (
		.on_panel (on_s2),
		.lx       (lx_s2),
		.ly       (ly_s2),
		.geom     (geom_calc)
	);

	// Stage 3: minutes = centiseconds / 6000.
	always_ff @(posedge clk) begin
		if (rdy[3]) begin
			qry_s3  <= qry_s2;
			cs_s3   <= prod10[DIV10_SH +: 29];
			geom_s3 <= geom_calc;
		end
	end

	assign prod6000 = 59'(cs_s3) * 59'(DIV6000_MUL);

	// Stage 4: remainder within the minute; minutes / 100.
	always_ff @(posedge clk) begin
		if (rdy[4]) begin
			qry_s4  <= qry_s3;
			cs_s4   <= cs_s3;
			qm_s4   <= prod6000[DIV6000_SH +: 17];
			geom_s4 <= geom_s3;
		end
	end

	assign rem_full = cs_s4 - 29'(qm_s4) * 29'(CS_PER_MIN);
	assign prod_qh  = 35'(qm_s4) * 35'(DIV100Q_MUL);

	// Stage 5: minutes modulo 100; seconds = remainder / 100.
	always_ff @(posedge clk) begin
		if (rdy[5]) begin
			qry_s5  <= qry_s4;
			qm_s5   <= qm_s4;
			qh_s5   <= prod_qh[DIV100Q_SH +: 10];
			rem_s5  <= rem_full[12:0];
			geom_s5 <= geom_s4;
		end
	end

	assign mm_full = qm_s5 - 17'(qh_s5) * 17'(HUNDRED);
	assign prod_sq = 27'(rem_s5) * 27'(DIV100R_MUL);

	// Stage 6: centiseconds within the second, decimal digits, pixel color.
	always_ff @(posedge clk) begin
		if (rdy[6]) begin
			qry_s6  <= qry_s5;
			mm_s6   <= mm_full[6:0];
			sq_s6   <= prod_sq[DIV100R_SH +: 6];
			rem_s6  <= rem_s5;
			geom_s6 <= geom_s5;
		end
	end

	always_comb begin
		cs_full = rem_s6 - 13'(sq_s6) * 13'(HUNDRED);
		mm_dec  = dec_split(mm_s6);
		ss_dec  = dec_split({1'b0, sq_s6});
		cs_dec  = dec_split(cs_full[6:0]);
		tick_digits[0] = mm_dec[7:4];
		tick_digits[1] = mm_dec[3:0];
		tick_digits[2] = ss_dec[7:4];
		tick_digits[3] = ss_dec[3:0];
		tick_digits[4] = cs_dec[7:4];
		tick_digits[5] = cs_dec[3:0];
	end

	swr_glyph u_glyph (
		.geom   (geom_s6),
		.digits (digit_q),
		.hit    (pix_hit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_q <= '0;
		end else if (vld_q[6] && out_rdy && !qry_s6) begin
			digit_q <= tick_digits;
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (out_rdy) begin
			rsp_qry_q <= qry_s6;
			if (qry_s6) begin
				rsp_q.minute_tens  <= digit_q[0];
				rsp_q.minute_units <= digit_q[1];
				rsp_q.second_tens  <= digit_q[2];
				rsp_q.second_units <= digit_q[3];
				rsp_q.centi_tens   <= digit_q[4];
				rsp_q.centi_units  <= digit_q[5];
				rsp_q.pixel_color  <= pix_hit ? fg_q : bg_q;
			end else begin
				rsp_q.minute_tens  <= tick_digits[0];
				rsp_q.minute_units <= tick_digits[1];
				rsp_q.second_tens  <= tick_digits[2];
				rsp_q.second_units <= tick_digits[3];
				rsp_q.centi_tens   <= tick_digits[4];
				rsp_q.centi_units  <= tick_digits[5];
				rsp_q.pixel_color  <= 16'h0000;
			end
		end
	end

	// A tick leaving the pipeline shows exactly the digits it stores.
	a_tick_digits: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q[6] && out_rdy && !qry_s6) |=>
			(rsp_data.minute_tens == digit_q[0] && rsp_data.minute_units == digit_q[1]
			&& rsp_data.second_tens == digit_q[2] && rsp_data.second_units == digit_q[3]
			&& rsp_data.centi_tens == digit_q[4] && rsp_data.centi_units == digit_q[5]))
		else $error("tick result digits differ from stored digits");

	// A query result is always one of the two configured colors.
	a_query_color: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_qry_q) |->
			(rsp_data.pixel_color == fg_q || rsp_data.pixel_color == bg_q))
		else $error("query color is neither foreground nor background");

	// The conversion never produces a digit above nine, nor a second tens digit above five.
	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_data.minute_tens <= 4'd9 && rsp_data.minute_units <= 4'd9
			&& rsp_data.second_tens <= 4'd5 && rsp_data.second_units <= 4'd9
			&& rsp_data.centi_tens <= 4'd9 && rsp_data.centi_units <= 4'd9))
		else $error("digit out of range");

endmodule

@@ test/stopwatch_seven_segment_renderer_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for stopwatch_seven_segment_renderer: a directed table of ticks and
// pixel queries, then random traffic under four color settings, checked by a behavioral predictor.
// Depends on swr_pkg and the stopwatch_seven_segment_renderer RTL.
module stopwatch_seven_segment_renderer_tb;
	import swr_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 12;
	localparam int PHASE_ITEMS  = 300;
	localparam int FACE_ROW     = 124;
	localparam int DIGIT_W      = 48;
	localparam int DIGIT_H      = 120;
	localparam int BAR          = 18;

	typedef struct {
		swr_req_t req;
		bit       typed;
		swr_rsp_t want;
	} directed_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 req_valid;
	logic                 req_stall;
	swr_req_t             req_data;
	logic                 rsp_valid;
	logic                 rsp_stall;
	swr_rsp_t             rsp_data;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [15:0]          cfg_data;

	logic [15:0]   model_fg;
	logic [15:0]   model_bg;
	bit            model_running;
	logic [31:0]   model_acc_ms;
	logic [31:0]   model_start_ms;
	logic [3:0]    model_digits [6];
	swr_rsp_t      pending_readouts [$];
	directed_row_t directed_items [$];
	logic [31:0]   wall_ms;
	bit            steady;
	int            error_count;
	int            cycle_count;

	stopwatch_seven_segment_renderer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic bit in_rect(int px, int py, int bx, int by, int bw, int bh);
		return px >= bx && px < bx + bw && py >= by && py < by + bh;
	endfunction

	function automatic logic [6:0] glyph_of(logic [3:0] d);
		case (d)
			4'd0: return 7'h3F;
			4'd1: return 7'h06;
			4'd2: return 7'h5B;
			4'd3: return 7'h4F;
			4'd4: return 7'h66;
			4'd5: return 7'h6D;
			4'd6: return 7'h7D;
			4'd7: return 7'h07;
			4'd8: return 7'h7F;
			4'd9: return 7'h6F;
			default: return 7'h00;
		endcase
	endfunction

	function automatic int digit_left(int i);
		case (i)
			0: return 14;
			1: return 74;
			2: return 170;
			3: return 230;
			4: return 326;
			default: return 386;
		endcase
	endfunction

	// Without a middle bar, a side whose upper and lower strokes are both lit is one tall stroke.
	function automatic bit digit_covers(int px, int py, int cx, logic [3:0] d);
		logic [6:0] s;
		int mid, up_y, up_h, lo_y, lo_h, full_h, rx;
		s = glyph_of(d);
		mid = FACE_ROW + DIGIT_H / 2 - BAR / 2;
		up_y = s[0] ? FACE_ROW + BAR : FACE_ROW;
		up_h = mid - up_y;
		lo_y = mid + BAR;
		lo_h = (s[3] ? FACE_ROW + DIGIT_H - BAR : FACE_ROW + DIGIT_H) - lo_y;
		full_h = lo_y + lo_h - up_y;
		rx = cx + DIGIT_W - BAR;
		if (s[0] && in_rect(px, py, cx, FACE_ROW, DIGIT_W, BAR)) return 1'b1;
		if (s[6] && in_rect(px, py, cx, mid, DIGIT_W, BAR)) return 1'b1;
		if (s[3] && in_rect(px, py, cx, FACE_ROW + DIGIT_H - BAR, DIGIT_W, BAR)) return 1'b1;
		if (!s[6] && s[5] && s[4]) begin
			if (in_rect(px, py, cx, up_y, BAR, full_h)) return 1'b1;
		end else begin
			if (s[5] && in_rect(px, py, cx, up_y, BAR, up_h)) return 1'b1;
			if (s[4] && in_rect(px, py, cx, lo_y, BAR, lo_h)) return 1'b1;
		end
		if (!s[6] && s[1] && s[2]) begin
			if (in_rect(px, py, rx, up_y, BAR, full_h)) return 1'b1;
		end else begin
			if (s[1] && in_rect(px, py, rx, up_y, BAR, up_h)) return 1'b1;
			if (s[2] && in_rect(px, py, rx, lo_y, BAR, lo_h)) return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic bit colon_covers(int px, int py, int cx);
		int dx;
		dx = cx + 3;
		if (in_rect(px, py, dx, FACE_ROW + DIGIT_H / 3 - BAR / 2, BAR, BAR)) return 1'b1;
		return in_rect(px, py, dx, FACE_ROW + 2 * DIGIT_H / 3 - BAR / 2, BAR, BAR);
	endfunction

	function automatic logic [15:0] predict_pixel(logic [8:0] x, logic [8:0] y);
		int lx, ly, i;
		if (x >= 9'(PANEL_WIDTH) || y >= 9'(PANEL_HEIGHT)) return model_bg;
		lx = int'(y);
		ly = PANEL_WIDTH - 1 - int'(x);
		if (colon_covers(lx, ly, 134) || colon_covers(lx, ly, 290)) return model_fg;
		for (i = 0; i < 6; i++) begin
			if (digit_covers(lx, ly, digit_left(i), model_digits[i])) return model_fg;
		end
		return model_bg;
	endfunction

	function automatic swr_rsp_t predict_readout(swr_req_t r);
		swr_rsp_t readout;
		logic [31:0] shown, centis, mins, secs, cs;
		readout.pixel_color = 16'h0000;
		if (r.req_type) begin
			readout.pixel_color = predict_pixel(r.pixel_x, r.pixel_y);
		end else begin
			if (r.boot_reset) begin
				model_running = 1'b0;
				model_acc_ms = 32'd0;
			end
			if (r.short_press) begin
				if (model_running) begin
					model_acc_ms = model_acc_ms + (r.now_ms - model_start_ms);
					model_running = 1'b0;
				end else begin
					model_start_ms = r.now_ms;
					model_running = 1'b1;
				end
			end
			shown = model_running ? model_acc_ms + (r.now_ms - model_start_ms) : model_acc_ms;
			centis = shown / 10;
			mins = (centis / 6000) % 100;
			secs = (centis / 100) % 60;
			cs = centis % 100;
			model_digits[0] = 4'(mins / 10);
			model_digits[1] = 4'(mins % 10);
			model_digits[2] = 4'(secs / 10);
			model_digits[3] = 4'(secs % 10);
			model_digits[4] = 4'(cs / 10);
			model_digits[5] = 4'(cs % 10);
		end
		readout.minute_tens = model_digits[0];
		readout.minute_units = model_digits[1];
		readout.second_tens = model_digits[2];
		readout.second_units = model_digits[3];
		readout.centi_tens = model_digits[4];
		readout.centi_units = model_digits[5];
		return readout;
	endfunction

	function automatic swr_req_t tick_req(logic [31:0] now, bit rst, bit press);
		swr_req_t r;
		r.req_type = 1'b0;
		r.now_ms = now;
		r.boot_reset = rst;
		r.short_press = press;
		r.pixel_x = 9'($urandom);
		r.pixel_y = 9'($urandom);
		return r;
	endfunction

	function automatic swr_req_t pixel_req(int x, int y);
		swr_req_t r;
		r.req_type = 1'b1;
		r.now_ms = $urandom;
		r.boot_reset = 1'($urandom_range(1));
		r.short_press = 1'($urandom_range(1));
		r.pixel_x = 9'(x);
		r.pixel_y = 9'(y);
		return r;
	endfunction

	// Mostly queries over the face band, plus a running clock with presses and rare resets.
	function automatic swr_req_t random_item();
		int pick, ly;
		pick = $urandom_range(99);
		if (pick < 72) begin
			pick = $urandom_range(99);
			ly = $urandom_range(253, 115);
			if (pick < 70) return pixel_req(PANEL_WIDTH - 1 - ly, $urandom_range(447));
			if (pick < 90) return pixel_req($urandom_range(367), $urandom_range(447));
			return pixel_req($urandom_range(511), $urandom_range(511));
		end
		pick = $urandom_range(99);
		if (pick < 12) return tick_req($urandom, 1'($urandom_range(1)), 1'($urandom_range(1)));
		if (pick < 60) wall_ms = wall_ms + $urandom_range(2000);
		else if (pick < 90) wall_ms = wall_ms + $urandom_range(200000);
		else wall_ms = wall_ms + $urandom_range(10000000);
		return tick_req(wall_ms, $urandom_range(99) < 5, $urandom_range(99) < 25);
	endfunction

	task automatic add_row(swr_req_t r, bit typed, logic [39:0] want);
		directed_row_t row;
		row.req = r;
		row.typed = typed;
		row.want = want;
		directed_items.push_back(row);
	endtask

	task automatic send_request(swr_req_t r, bit typed, swr_rsp_t want);
		swr_rsp_t predicted;
		@(negedge clk);
		while (!steady && $urandom_range(99) < 14) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req_data <= r;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		predicted = predict_readout(r);
		pending_readouts.push_back(typed ? want : predicted);
	endtask

	task automatic settle();
		@(negedge clk);
		req_valid <= 1'b0;
		while (pending_readouts.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_color(logic [CFG_IDX_W-1:0] idx, logic [15:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_FG_COLOR) model_fg = value;
		else model_bg = value;
	endtask

	task automatic check_readout(swr_rsp_t got);
		swr_rsp_t want;
		logic [15:0] w [7];
		logic [15:0] g [7];
		string names [7];
		int k;
		if (pending_readouts.size() == 0) begin
			$display("%0t: unexpected transaction %h", $time, got);
			error_count++;
			return;
		end
		want = pending_readouts.pop_front();
		names = '{"minute_tens", "minute_units", "second_tens", "second_units",
			"centi_tens", "centi_units", "pixel_color"};
		w = '{16'(want.minute_tens), 16'(want.minute_units), 16'(want.second_tens),
			16'(want.second_units), 16'(want.centi_tens), 16'(want.centi_units),
			want.pixel_color};
		g = '{16'(got.minute_tens), 16'(got.minute_units), 16'(got.second_tens),
			16'(got.second_units), 16'(got.centi_tens), 16'(got.centi_units),
			got.pixel_color};
		for (k = 0; k < 7; k++) begin
			if (w[k] !== g[k]) begin
				$display("%0t: %s expected %h, actual %h", $time, names[k], w[k], g[k]);
				error_count++;
			end
		end
	endtask

	always @(negedge clk) begin
		rsp_stall <= !steady && $urandom_range(99) < 14;
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) check_readout(rsp_data);
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("stopwatch_seven_segment_renderer_tb: FAIL");
		$finish;
	end

	initial begin
		logic [15:0] fg, bg;
		int i;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req_data = '0;
		rsp_stall = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		steady = 1'b0;
		error_count = 0;
		wall_ms = $urandom;
		model_fg = 16'h0000;
		model_bg = 16'hFFFF;
		model_running = 1'b0;
		model_acc_ms = 32'd0;
		model_start_ms = 32'd0;
		for (i = 0; i < 6; i++) model_digits[i] = 4'd0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		add_row(pixel_req(0, 0), 1'b1, 40'h000000_FFFF);
		add_row(pixel_req(367, 447), 1'b1, 40'h000000_FFFF);
		add_row(pixel_req(368, 0), 1'b1, 40'h000000_FFFF);
		add_row(pixel_req(0, 448), 1'b1, 40'h000000_FFFF);
		add_row(pixel_req(511, 511), 1'b1, 40'h000000_FFFF);
		add_row(pixel_req(207, 140), 1'b1, 40'h000000_0000);
		add_row(pixel_req(187, 20), 1'b1, 40'h000000_0000);
		add_row(pixel_req(187, 38), 1'b1, 40'h000000_FFFF);
		add_row(tick_req(32'd0, 1'b0, 1'b0), 1'b1, 40'h000000_0000);
		add_row(tick_req(32'd1000, 1'b0, 1'b1), 1'b1, 40'h000000_0000);
		add_row(tick_req(32'd62230, 1'b0, 1'b0), 1'b1, 40'h010123_0000);
		add_row(pixel_req(187, 20), 1'b0, 40'h0);
		add_row(tick_req(32'd70000, 1'b0, 1'b1), 1'b1, 40'h010900_0000);
		add_row(tick_req(32'd99999, 1'b0, 1'b0), 1'b0, 40'h0);
		add_row(tick_req(32'hFFFF_FFF0, 1'b0, 1'b1), 1'b0, 40'h0);
		add_row(tick_req(32'd16, 1'b0, 1'b0), 1'b0, 40'h0);
		add_row(tick_req(32'd5, 1'b1, 1'b1), 1'b1, 40'h000000_0000);
		add_row(tick_req(32'hFFFF_FFFF, 1'b1, 1'b0), 1'b1, 40'h000000_0000);
		add_row(tick_req(32'd0, 1'b0, 1'b1), 1'b1, 40'h000000_0000);
		add_row(tick_req(32'hFFFF_FFFF, 1'b0, 1'b0), 1'b1, 40'h824729_0000);
		add_row(pixel_req(187, 38), 1'b0, 40'h0);
		add_row(tick_req(32'd0, 1'b1, 1'b0), 1'b1, 40'h000000_0000);
		foreach (directed_items[n]) begin
			send_request(directed_items[n].req, directed_items[n].typed, directed_items[n].want);
		end

		for (int phase = 0; phase < 4; phase++) begin
			settle();
			case (phase)
				0: begin
					fg = 16'hFFFF;
					bg = 16'h0000;
				end
				2: begin
					fg = 16'h0000;
					bg = 16'hFFFF;
				end
				default: begin
					fg = 16'($urandom);
					bg = 16'($urandom);
				end
			endcase
			write_color(CFG_FG_COLOR, fg);
			write_color(CFG_BG_COLOR, bg);
			steady = (phase == 1);
			repeat (PHASE_ITEMS) send_request(random_item(), 1'b0, '0);
		end
		settle();

		if (error_count == 0) begin
			$display("stopwatch_seven_segment_renderer_tb: PASS");
		end else begin
			$display("stopwatch_seven_segment_renderer_tb: FAIL");
		end
		$finish;
	end

endmodule
